FILE: rtl/fsc_pkg.sv
// fsc_pkg: single-precision constants and arithmetic helpers for the sine/cosine pipeline
// holds the round-to-nearest-even multiply, add and pack functions
// no dependencies
`timescale 1ns / 1ps

package fsc_pkg;

  // opcodes
  localparam logic OP_SIN = 1'b0;
  localparam logic OP_COS = 1'b1;

  // single-precision constants as bit patterns
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [31:0] HALF_PI   = 32'h3FC9_0FDB;
  localparam logic [31:0] Y_LIMIT   = 32'h4649_0C00;
  localparam logic [31:0] INV_PI    = 32'h3EA2_F983;
  localparam logic [31:0] RED_C1    = 32'h4049_0000;
  localparam logic [31:0] RED_C2    = 32'h3A7D_AA22;
  localparam logic [31:0] SMALL_F   = 32'h3980_0000;
  localparam logic [31:0] POLY_R1   = 32'hBE2A_AAA4;
  localparam logic [31:0] POLY_R2   = 32'h3C08_873E;
  localparam logic [31:0] POLY_R3   = 32'hB94F_B222;
  localparam logic [31:0] POLY_R4   = 32'h362E_9C5B;

  // biased exponent where an integer mantissa maps to its own value
  localparam logic signed [11:0] INT_EXP  = 12'sd175;
  localparam logic signed [11:0] HALF_EXP = 12'sd174;

  // leading zero count of a 50-bit word
  function automatic logic [5:0] lzc50(input logic [49:0] m);
    logic [5:0] n;
    logic       found;
    n     = 6'd50;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found && m[i]) begin
        n     = 6'(49 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // value = m / 2^48 * 2^(e - 127); normalize, round to nearest even, pack
  function automatic logic [31:0] fpack(input logic s, input logic signed [11:0] e,
                                        input logic [49:0] m);
    logic [5:0]         lz;
    logic [49:0]        mn;
    logic [49:0]        lost;
    logic signed [11:0] e2;
    logic [5:0]         sh;
    logic [9:0]         eb;
    logic               g;
    logic               st;
    logic [24:0]        r;
    logic [32:0]        sum;
    lz = lzc50(m);
    mn = m << lz;
    e2 = e + 12'sd1 - $signed({6'd0, lz});
    eb = 10'd0;
    if (e2 <= 12'sd0) begin
      // subnormal: align to the minimum exponent, fold lost bits into sticky
      if (e2 < -12'sd48) sh = 6'd50;
      else sh = 6'(12'sd1 - e2);
      lost = mn << (6'd50 - sh);
      mn   = (mn >> sh) | {49'd0, |lost};
    end else begin
      eb = 10'(e2 - 12'sd1);
    end
    g   = mn[25];
    st  = |mn[24:0];
    r   = {1'b0, mn[49:26]} + {24'd0, g & (st | mn[26])};
    sum = {eb, 23'd0} + {8'd0, r};
    if (m == 50'd0) return {s, 31'd0};
    else if (sum >= 33'h0_7F80_0000) return {s, 8'hFF, 23'd0};
    else return {s, sum[30:0]};
  endfunction

  // single-precision multiply
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        p;
    logic signed [11:0] e;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd125;
    return fpack(a[31] ^ b[31], e, {2'b00, p});
  endfunction

  // single-precision add
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        sa;
    logic        sb;
    logic [7:0]  et;
    logic [23:0] mt;
    logic        stt;
    logic [7:0]  d;
    logic [49:0] af;
    logic [49:0] bf;
    logic [49:0] lost;
    logic [49:0] sum;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    sa = a[31];
    sb = b[31];
    // larger magnitude goes first
    if ({ea, ma} < {eb, mb}) begin
      et = ea;  ea = eb;  eb = et;
      mt = ma;  ma = mb;  mb = mt;
      stt = sa; sa = sb;  sb = stt;
    end
    d  = ea - eb;
    af = {1'b0, ma, 25'd0};
    bf = {1'b0, mb, 25'd0};
    if (d >= 8'd50) begin
      bf = {49'd0, |mb};
    end else begin
      lost = bf << (8'd50 - d);
      bf   = (bf >> d) | {49'd0, |lost};
    end
    sum = (sa == sb) ? af + bf : af - bf;
    if (sum == 50'd0) return {(sa == sb) ? sa : 1'b0, 31'd0};
    else return fpack(sa, $signed({4'd0, ea}), sum);
  endfunction

endpackage

FILE: rtl/fsc_if.sv
// fsc_req_if / fsc_rsp_if: valid/ready channels for operand requests and results
// depends on nothing
`timescale 1ns / 1ps

interface fsc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] operand_bits;
  modport source (output valid, opcode, operand_bits, input ready);
  modport sink   (input valid, opcode, operand_bits, output ready);
endinterface

interface fsc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  modport source (output valid, result_bits, input ready);
  modport sink   (input valid, result_bits, output ready);
endinterface

FILE: rtl/float_sine_cosine.sv
// Single-precision sine/cosine with two-constant argument reduction.
// One request is taken every cycle while results drain.
// Most of the 17 register stages hold one float multiply or add (stage four holds two
// multiplies); stage three rounds n and converts it to float, the last stage applies the sign.
// All stages stall together only when the last stage holds a result that rsp is not taking.
// Out-of-range arguments (|x| or |x|+pi/2 at least 12867), infinities and NaN give +0.
// Depends on fsc_pkg and fsc_if.
`timescale 1ns / 1ps

module float_sine_cosine
  import fsc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fsc_req_if.sink   req,
  fsc_rsp_if.source rsp
);

  localparam int NSTAGE = 17;

  typedef struct packed {
    logic        valid;
    logic        cosf;
    logic        neg;
    logic        oor;
    logic        near_zero;
    logic [31:0] ax;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] p2;
    logic [31:0] acc;
  } stage_t;

  stage_t stg [1:NSTAGE];
  stage_t nxt [1:NSTAGE];
  logic   adv;

  // whole pipe advances unless a finished result is held
  assign adv       = !stg[NSTAGE].valid || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = stg[NSTAGE].valid;
  assign rsp.result_bits = stg[NSTAGE].acc;

  always_comb begin
    logic [7:0]  te;
    logic [23:0] q;
    logic [13:0] nn;
    logic [31:0] res;
    te  = stg[2].acc[30:23];
    q   = 24'd0;
    res = 32'd0;

    // stage 1: magnitude, sign of sine, y
    nxt[1]       = '0;
    nxt[1].valid = req.valid;
    nxt[1].cosf  = req.opcode;
    nxt[1].ax    = {1'b0, req.operand_bits[30:0]};
    nxt[1].neg   = (req.opcode == OP_SIN) && req.operand_bits[31]
                   && (req.operand_bits[30:0] != 31'd0);
    nxt[1].acc   = (req.opcode == OP_COS)
                   ? fadd({1'b0, req.operand_bits[30:0]}, HALF_PI)
                   : {1'b0, req.operand_bits[30:0]};

    // stage 2: range check, t = y / pi
    nxt[2]     = stg[1];
    nxt[2].oor = !(stg[1].acc < Y_LIMIT);
    nxt[2].acc = fmul(stg[1].acc, INV_PI);

    // stage 3: n = round half up of t, xn as float
    if (te < 8'd126) q = 24'd0;
    else if (te > 8'd149) q = {1'b1, stg[2].acc[22:0]};
    else q = {1'b1, stg[2].acc[22:0]} >> 5'(8'd149 - te);
    nn         = 14'((q + 24'd1) >> 1);
    nxt[3]     = stg[2];
    nxt[3].neg = stg[2].neg ^ nn[0];
    if (stg[2].cosf == OP_COS) begin
      if (nn == 14'd0) nxt[3].acc = fpack(1'b1, HALF_EXP, 50'd1);
      else nxt[3].acc = fpack(1'b0, HALF_EXP, 50'({nn, 1'b0} - 15'd1));
    end else begin
      nxt[3].acc = fpack(1'b0, INT_EXP, 50'(nn));
    end

    // stage 4: xn*C1 and xn*C2
    nxt[4]     = stg[3];
    nxt[4].acc = fmul(stg[3].acc, RED_C1);
    nxt[4].p2  = fmul(stg[3].acc, RED_C2);

    // stage 5: |x| - xn*C1
    nxt[5]     = stg[4];
    nxt[5].acc = fadd(stg[4].ax, stg[4].acc ^ SIGN_MASK);

    // stage 6: reduced argument f
    nxt[6]           = stg[5];
    nxt[6].f         = fadd(stg[5].acc, stg[5].p2 ^ SIGN_MASK);
    nxt[6].near_zero = (nxt[6].f[30:0] < SMALL_F[30:0]);

    // stage 7: g = f*f
    nxt[7]   = stg[6];
    nxt[7].g = fmul(stg[6].f, stg[6].f);

    // stages 8 to 14: horner evaluation of R(g)
    nxt[8]      = stg[7];
    nxt[8].acc  = fmul(POLY_R4, stg[7].g);
    nxt[9]      = stg[8];
    nxt[9].acc  = fadd(stg[8].acc, POLY_R3);
    nxt[10]     = stg[9];
    nxt[10].acc = fmul(stg[9].acc, stg[9].g);
    nxt[11]     = stg[10];
    nxt[11].acc = fadd(stg[10].acc, POLY_R2);
    nxt[12]     = stg[11];
    nxt[12].acc = fmul(stg[11].acc, stg[11].g);
    nxt[13]     = stg[12];
    nxt[13].acc = fadd(stg[12].acc, POLY_R1);
    nxt[14]     = stg[13];
    nxt[14].acc = fmul(stg[13].acc, stg[13].g);

    // stages 15 and 16: f + R(g)*f
    nxt[15]     = stg[14];
    nxt[15].acc = fmul(stg[14].acc, stg[14].f);
    nxt[16]     = stg[15];
    nxt[16].acc = fadd(stg[15].f, stg[15].acc);

    // stage 17: small-argument bypass, sign, range override
    res         = stg[16].near_zero ? stg[16].f : stg[16].acc;
    res         = res ^ {stg[16].neg, 31'd0};
    nxt[17]     = stg[16];
    nxt[17].acc = stg[16].oor ? 32'd0 : res;
  end

  // pipeline registers, valid bits cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTAGE; k++) begin
        stg[k].valid <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 1; k <= NSTAGE; k++) begin
        stg[k] <= nxt[k];
      end
    end
  end

  // an accepted request occupies the first stage next cycle
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> stg[1].valid)
    else $error("accepted request did not enter the pipeline");

  // out-of-range results are positive zero
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    stg[NSTAGE].valid && stg[NSTAGE].oor |-> rsp.result_bits == 32'd0)
    else $error("out-of-range result not zero");

  // bypassed small arguments stay below the threshold
  a_small_mag: assert property (@(posedge clk) disable iff (rst)
    stg[NSTAGE].valid && stg[NSTAGE].near_zero && !stg[NSTAGE].oor
      |-> rsp.result_bits[30:0] < SMALL_F[30:0])
    else $error("small-argument result out of bound");

  // a held result keeps the stage behind it frozen
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stg[NSTAGE].valid && !rsp.ready |=> $stable(stg[NSTAGE - 1].valid))
    else $error("pipeline moved during stall");

endmodule
